// ===== hw/rtl/lchf_pkg.sv =====
package lchf_pkg;

  typedef enum logic [1:0] {
    CFG_LAYER_RADIUS = 2'd0,
    CFG_HALF_LENGTH  = 2'd1,
    CFG_PT_MIN       = 2'd2,
    CFG_FIELD_ON     = 2'd3
  } cfg_reg_e;

  localparam int unsigned SQRT_STEPS = 46;
  localparam int unsigned SQRT_LAT   = SQRT_STEPS + 1;
  localparam int unsigned RAD_W      = 2 * SQRT_STEPS;
  localparam int unsigned ROOT_W     = SQRT_STEPS;

  localparam int unsigned MAG_W      = 21;
  localparam int unsigned NUM_W      = 46;
  localparam int unsigned DEN_W      = 42;
  localparam int unsigned Q_W        = 41;
  localparam int unsigned DIV_STEPS  = Q_W;
  localparam int unsigned SCALE_LAT  = DIV_STEPS + 4;

  typedef struct packed {
    logic [23:0] sx;
    logic [23:0] sy;
    logic [23:0] sz;
    logic [31:0] st;
    logic [20:0] mx;
    logic [20:0] my;
    logic [20:0] mz;
    logic [19:0] en;
  } ray_t;

  typedef struct packed {
    ray_t        ray;
    logic [45:0] dot;
    logic [41:0] ptsq;
  } pre_t;

  typedef struct packed {
    ray_t             ray;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } mid_t;

endpackage

// ===== hw/rtl/lchf_sqrt.sv =====
module lchf_sqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic [lchf_pkg::RAD_W-1:0]   rad_i,
  output logic                         valid_o,
  output logic [lchf_pkg::ROOT_W-1:0]  root_o
);

  logic                        v_q    [0:lchf_pkg::SQRT_STEPS];
  logic [lchf_pkg::ROOT_W-1:0] root_q [0:lchf_pkg::SQRT_STEPS];
  logic [lchf_pkg::ROOT_W:0]   rem_q  [0:lchf_pkg::SQRT_STEPS-1];
  logic [lchf_pkg::RAD_W-1:0]  val_q  [0:lchf_pkg::SQRT_STEPS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q[0]  <= rad_i;
    rem_q[0]  <= '0;
    root_q[0] <= '0;
  end

  for (genvar k = 0; k < lchf_pkg::SQRT_STEPS; k++) begin : g_step
    logic [lchf_pkg::ROOT_W+2:0] trial;
    logic [lchf_pkg::ROOT_W+2:0] sub;
    logic [lchf_pkg::ROOT_W+2:0] dif;
    logic                        ge;

    assign trial = {rem_q[k], val_q[k][lchf_pkg::RAD_W-1 -: 2]};
    assign sub   = {1'b0, root_q[k], 2'b01};
    assign dif   = trial - sub;
    assign ge    = trial >= sub;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      root_q[k+1] <= {root_q[k][lchf_pkg::ROOT_W-2:0], ge};
    end

    if (k < lchf_pkg::SQRT_STEPS - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        rem_q[k+1] <= ge ? dif[lchf_pkg::ROOT_W:0] : trial[lchf_pkg::ROOT_W:0];
        val_q[k+1] <= {val_q[k][lchf_pkg::RAD_W-3:0], 2'b00};
      end
    end
  end

  assign valid_o = v_q[lchf_pkg::SQRT_STEPS];
  assign root_o  = root_q[lchf_pkg::SQRT_STEPS];

endmodule

// ===== hw/rtl/lchf_scale.sv =====
module lchf_scale (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [lchf_pkg::MAG_W-1:0] mag_i,
  input  logic [lchf_pkg::NUM_W-1:0] num_i,
  input  logic [lchf_pkg::DEN_W-1:0] den_i,
  output logic                       valid_o,
  output logic [lchf_pkg::Q_W-1:0]   q_o
);

  localparam int unsigned NW = 68;
  localparam int unsigned DW = lchf_pkg::DEN_W + 1;
  localparam int unsigned L  = lchf_pkg::DIV_STEPS;

  logic                    p_v_q;
  logic [43:0]             plo_q;
  logic [43:0]             phi_q;
  logic [lchf_pkg::DEN_W-1:0] pden_q;

  logic                    n_v_q;
  logic [NW-1:0]           n_num_q;
  logic [DW-1:0]           n_div_q;

  logic                    v_q   [0:L];
  logic [lchf_pkg::Q_W-1:0] quo_q [0:L];
  logic                    sat_q [0:L];
  logic [DW-1:0]           rem_q [0:L-1];
  logic [lchf_pkg::Q_W-1:0] low_q [0:L-1];
  logic [DW-1:0]           dv_q  [0:L-1];

  logic [DW-1:0]           head;
  logic                    over;
  logic                    out_v_q;
  logic [lchf_pkg::Q_W-1:0] out_q_q;

  assign head = {{(DW - (NW - lchf_pkg::Q_W)){1'b0}}, n_num_q[NW-1:lchf_pkg::Q_W]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q   <= 1'b0;
      n_v_q   <= 1'b0;
      v_q[0]  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      p_v_q   <= valid_i;
      n_v_q   <= p_v_q;
      v_q[0]  <= n_v_q;
      out_v_q <= v_q[L];
    end
  end

  always_ff @(posedge clk_i) begin
    plo_q    <= mag_i * num_i[22:0];
    phi_q    <= mag_i * num_i[45:23];
    pden_q   <= den_i;
    n_num_q  <= {phi_q, 24'b0} + {23'b0, plo_q, 1'b0} + {26'b0, pden_q};
    n_div_q  <= {pden_q, 1'b0};
    rem_q[0] <= head;
    low_q[0] <= n_num_q[lchf_pkg::Q_W-1:0];
    dv_q[0]  <= n_div_q;
    quo_q[0] <= '0;
    sat_q[0] <= head >= n_div_q;
  end

  for (genvar k = 0; k < L; k++) begin : g_step
    logic [DW:0] trial;
    logic [DW:0] dif;
    logic        ge;

    assign trial = {rem_q[k], low_q[k][lchf_pkg::Q_W-1]};
    assign dif   = trial - {1'b0, dv_q[k]};
    assign ge    = trial >= {1'b0, dv_q[k]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      quo_q[k+1] <= {quo_q[k][lchf_pkg::Q_W-2:0], ge};
      sat_q[k+1] <= sat_q[k];
    end

    if (k < L - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        rem_q[k+1] <= ge ? dif[DW-1:0] : trial[DW-1:0];
        low_q[k+1] <= {low_q[k][lchf_pkg::Q_W-2:0], 1'b0};
        dv_q[k+1]  <= dv_q[k];
      end
    end
  end

  // quotient above the step limit saturates
  assign over = sat_q[L] || (quo_q[L][lchf_pkg::Q_W-1] && |quo_q[L][lchf_pkg::Q_W-2:0]);

  always_ff @(posedge clk_i) begin
    out_q_q <= over ? {1'b1, {(lchf_pkg::Q_W-1){1'b0}}} : quo_q[L];
  end

  assign valid_o = out_v_q;
  assign q_o     = out_q_q;

endmodule

// ===== hw/rtl/line_cylinder_hit_finder.sv =====
// Straight-track barrel hit finder.
// Input channel: an item (start point, start time, momentum, energy, charge) is
// taken at each rising edge with start_i high and busy_o low. busy_o stays low,
// so a new item can enter in every cycle.
// Result channel: done_o is high for one cycle with hit_x_o, hit_y_o, hit_z_o
// and hit_time_o; an item that yields no hit gives no strobe. Results come out
// in input order through six front stages, the 47-stage square root and two
// 45-stage scaled dividers in series (the second runs once the end cap decision
// is known). Throughput is one item per cycle. The receiver cannot stall, so
// nothing is held back.
// Configuration: cfg_valid_i with cfg_index_i and cfg_data_i writes a register;
// cfg_ready_o is always high. Write only while no item is in flight.
// Reset clears all valid bits and loads the register defaults (radius 100000,
// half length 1000000, pt minimum 1000, field off).
module line_cylinder_hit_finder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [22:0]        cfg_data_i,
  input  logic signed [23:0] start_x_i,
  input  logic signed [23:0] start_y_i,
  input  logic signed [23:0] start_z_i,
  input  logic signed [31:0] start_time_i,
  input  logic signed [20:0] mom_x_i,
  input  logic signed [20:0] mom_y_i,
  input  logic signed [20:0] mom_z_i,
  input  logic [19:0]        energy_i,
  input  logic signed [1:0]  charge_i,
  output logic               done_o,
  output logic signed [23:0] hit_x_o,
  output logic signed [23:0] hit_y_o,
  output logic signed [23:0] hit_z_o,
  output logic signed [31:0] hit_time_o
);

  function automatic logic [20:0] mag21(logic [20:0] v);
    logic [20:0] n;
    n = 21'd0 - v;
    return v[20] ? n : v;
  endfunction

  function automatic logic signed [42:0] apply(logic [20:0] m, logic [40:0] q);
    logic signed [42:0] qs;
    qs = $signed({2'b00, q});
    return m[20] ? -qs : qs;
  endfunction

  function automatic logic [23:0] clamp24(logic signed [42:0] v);
    logic [23:0] r;
    if (v > 43'sd8388607) r = 24'h7FFFFF;
    else if (v < -43'sd8388608) r = 24'h800000;
    else r = v[23:0];
    return r;
  endfunction

  function automatic logic [31:0] clamp32(logic signed [41:0] v);
    logic [31:0] r;
    if (v > 42'sd2147483647) r = 32'h7FFFFFFF;
    else if (v < -42'sd2147483648) r = 32'h80000000;
    else r = v[31:0];
    return r;
  endfunction

  // configuration
  logic [22:0] radius_q;
  logic [22:0] half_q;
  logic [19:0] ptmin_q;
  logic        field_q;
  logic [45:0] rsq_q;
  logic [39:0] ptminsq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= 23'd100000;
      half_q   <= 23'd1000000;
      ptmin_q  <= 20'd1000;
      field_q  <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        lchf_pkg::CFG_LAYER_RADIUS: radius_q <= cfg_data_i;
        lchf_pkg::CFG_HALF_LENGTH:  half_q   <= cfg_data_i;
        lchf_pkg::CFG_PT_MIN:       ptmin_q  <= cfg_data_i[19:0];
        lchf_pkg::CFG_FIELD_ON:     field_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    rsq_q     <= radius_q * radius_q;
    ptminsq_q <= ptmin_q * ptmin_q;
  end

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  // front stages
  logic                 a_v_q, b_v_q, c_v_q, d_v_q, e_v_q, f_v_q;
  lchf_pkg::ray_t       a_ray_q, b_ray_q, c_ray_q, d_ray_q, e_ray_q, f_ray_q;
  logic [1:0]           a_chg_q, b_chg_q;
  logic [46:0]          b_sxsq_q, b_sysq_q;
  logic [40:0]          b_mxsq_q, b_mysq_q;
  logic [44:0]          b_mxsx_q, b_mysy_q;
  logic [45:0]          c_r0sq_q, d_diff_q;
  logic [41:0]          c_ptsq_q, d_ptsq_q, e_ptsq_q, f_ptsq_q;
  logic [45:0]          c_dot_q, d_dot_q, e_dot_q, f_dot_q;
  logic [44:0]          d_dmag_q;
  logic [43:0]          e_p00_q, e_p01_q, e_p10_q, e_p11_q;
  logic [45:0]          e_q00_q;
  logic [44:0]          e_q01_q;
  logic [43:0]          e_q11_q;
  logic [89:0]          f_s1_q, f_s2_q;

  logic signed [47:0]   sxsq_w, sysq_w;
  logic signed [41:0]   mxsq_w, mysq_w;
  logic signed [44:0]   mxsx_w, mysy_w;
  logic [47:0]          r0sq_w;
  logic [41:0]          ptsq_w;
  logic [45:0]          dot_w, ndot_w;
  logic signed [24:0]   sz25_w, h25_w;
  logic                 kill_w;

  assign sxsq_w = $signed(a_ray_q.sx) * $signed(a_ray_q.sx);
  assign sysq_w = $signed(a_ray_q.sy) * $signed(a_ray_q.sy);
  assign mxsq_w = $signed(a_ray_q.mx) * $signed(a_ray_q.mx);
  assign mysq_w = $signed(a_ray_q.my) * $signed(a_ray_q.my);
  assign mxsx_w = $signed(a_ray_q.mx) * $signed(a_ray_q.sx);
  assign mysy_w = $signed(a_ray_q.my) * $signed(a_ray_q.sy);

  assign r0sq_w = {1'b0, b_sxsq_q} + {1'b0, b_sysq_q};
  assign ptsq_w = {1'b0, b_mxsq_q} + {1'b0, b_mysq_q};
  assign dot_w  = {b_mxsx_q[44], b_mxsx_q} + {b_mysy_q[44], b_mysy_q};
  assign sz25_w = $signed({b_ray_q.sz[23], b_ray_q.sz});
  assign h25_w  = $signed({2'b00, half_q});
  assign ndot_w = 46'd0 - c_dot_q;

  assign kill_w = (r0sq_w > {2'b00, rsq_q}) || (sz25_w > h25_w) || (sz25_w < -h25_w)
                  || (ptsq_w == 42'd0) || (ptsq_w < {2'b00, ptminsq_q})
                  || ((b_chg_q != 2'b00) && field_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
      e_v_q <= 1'b0;
      f_v_q <= 1'b0;
    end else begin
      a_v_q <= start_i && !busy_o;
      b_v_q <= a_v_q;
      c_v_q <= b_v_q && !kill_w;
      d_v_q <= c_v_q;
      e_v_q <= d_v_q;
      f_v_q <= e_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_ray_q <= '{sx: start_x_i, sy: start_y_i, sz: start_z_i, st: start_time_i,
                 mx: mom_x_i, my: mom_y_i, mz: mom_z_i, en: energy_i};
    a_chg_q <= charge_i;

    b_ray_q  <= a_ray_q;
    b_chg_q  <= a_chg_q;
    b_sxsq_q <= sxsq_w[46:0];
    b_sysq_q <= sysq_w[46:0];
    b_mxsq_q <= mxsq_w[40:0];
    b_mysq_q <= mysq_w[40:0];
    b_mxsx_q <= mxsx_w;
    b_mysy_q <= mysy_w;

    c_ray_q  <= b_ray_q;
    c_r0sq_q <= r0sq_w[45:0];
    c_ptsq_q <= ptsq_w;
    c_dot_q  <= dot_w;

    d_ray_q  <= c_ray_q;
    d_diff_q <= rsq_q - c_r0sq_q;
    d_dmag_q <= c_dot_q[45] ? ndot_w[44:0] : c_dot_q[44:0];
    d_ptsq_q <= c_ptsq_q;
    d_dot_q  <= c_dot_q;

    // split products of ptsq * (r^2 - r0^2) and dot^2
    e_ray_q  <= d_ray_q;
    e_ptsq_q <= d_ptsq_q;
    e_dot_q  <= d_dot_q;
    e_p00_q  <= d_ptsq_q[20:0] * d_diff_q[22:0];
    e_p01_q  <= d_ptsq_q[20:0] * d_diff_q[45:23];
    e_p10_q  <= d_ptsq_q[41:21] * d_diff_q[22:0];
    e_p11_q  <= d_ptsq_q[41:21] * d_diff_q[45:23];
    e_q00_q  <= d_dmag_q[22:0] * d_dmag_q[22:0];
    e_q01_q  <= d_dmag_q[22:0] * d_dmag_q[44:23];
    e_q11_q  <= d_dmag_q[44:23] * d_dmag_q[44:23];

    f_ray_q  <= e_ray_q;
    f_ptsq_q <= e_ptsq_q;
    f_dot_q  <= e_dot_q;
    f_s1_q   <= {2'b0, e_p11_q, 44'b0} + {25'b0, e_p10_q, 21'b0}
              + {23'b0, e_p01_q, 23'b0} + {46'b0, e_p00_q};
    f_s2_q   <= {e_q11_q, 46'b0} + {21'b0, e_q01_q, 24'b0} + {44'b0, e_q00_q};
  end

  // square root
  logic [89:0]                 disc_w;
  logic                        sq_v;
  logic [lchf_pkg::ROOT_W-1:0] sq_root;
  lchf_pkg::pre_t              sq_dl_q [0:lchf_pkg::SQRT_LAT-1];

  assign disc_w = f_s1_q + f_s2_q;

  lchf_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (f_v_q),
    .rad_i   ({2'b00, disc_w}),
    .valid_o (sq_v),
    .root_o  (sq_root)
  );

  always_ff @(posedge clk_i) begin
    sq_dl_q[0] <= '{ray: f_ray_q, dot: f_dot_q, ptsq: f_ptsq_q};
    for (int k = 1; k < lchf_pkg::SQRT_LAT; k++) begin
      sq_dl_q[k] <= sq_dl_q[k-1];
    end
  end

  // barrel step
  lchf_pkg::pre_t            sq_out;
  logic [47:0]               numr_w;
  logic                      h_v_q;
  lchf_pkg::ray_t            h_ray_q;
  logic [lchf_pkg::NUM_W-1:0] h_num_q;
  logic [lchf_pkg::DEN_W-1:0] h_den_q;

  assign sq_out = sq_dl_q[lchf_pkg::SQRT_LAT-1];
  assign numr_w = {2'b00, sq_root} - {{2{sq_out.dot[45]}}, sq_out.dot};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_v_q <= 1'b0;
    end else begin
      h_v_q <= sq_v && !numr_w[47];
    end
  end

  always_ff @(posedge clk_i) begin
    h_ray_q <= sq_out.ray;
    h_num_q <= numr_w[45:0];
    h_den_q <= sq_out.ptsq;
  end

  // z along the barrel step, end cap decision
  logic                     zs_v;
  logic [lchf_pkg::Q_W-1:0] zs_q;
  lchf_pkg::mid_t           z_dl_q [0:lchf_pkg::SCALE_LAT-1];

  lchf_scale u_scale_zb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (h_v_q),
    .mag_i   (mag21(h_ray_q.mz)),
    .num_i   (h_num_q),
    .den_i   (h_den_q),
    .valid_o (zs_v),
    .q_o     (zs_q)
  );

  always_ff @(posedge clk_i) begin
    z_dl_q[0] <= '{ray: h_ray_q, num: h_num_q, den: h_den_q};
    for (int k = 1; k < lchf_pkg::SCALE_LAT; k++) begin
      z_dl_q[k] <= z_dl_q[k-1];
    end
  end

  lchf_pkg::mid_t            z_out;
  logic signed [42:0]        zt_w, h43_w;
  logic signed [24:0]        szc_w, capp_w, capn_w;
  logic                      clip_w;
  logic                      i_v_q;
  lchf_pkg::ray_t            i_ray_q;
  logic [lchf_pkg::NUM_W-1:0] i_num_q;
  logic [lchf_pkg::DEN_W-1:0] i_den_q;

  assign z_out  = z_dl_q[lchf_pkg::SCALE_LAT-1];
  assign zt_w   = $signed({{19{z_out.ray.sz[23]}}, z_out.ray.sz}) + apply(z_out.ray.mz, zs_q);
  assign h43_w  = $signed({20'b0, half_q});
  assign szc_w  = $signed({z_out.ray.sz[23], z_out.ray.sz});
  assign capp_w = $signed({2'b00, half_q}) - szc_w;
  assign capn_w = $signed({2'b00, half_q}) + szc_w;
  assign clip_w = ((zt_w > h43_w) || (zt_w < -h43_w)) && (z_out.ray.mz != 21'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_v_q <= 1'b0;
    end else begin
      i_v_q <= zs_v;
    end
  end

  always_ff @(posedge clk_i) begin
    i_ray_q <= z_out.ray;
    if (clip_w) begin
      i_num_q <= z_out.ray.mz[20] ? {22'b0, capn_w[23:0]} : {22'b0, capp_w[23:0]};
      i_den_q <= {21'b0, mag21(z_out.ray.mz)};
    end else begin
      i_num_q <= z_out.num;
      i_den_q <= z_out.den;
    end
  end

  // final step along all components
  logic                     fx_v, fy_v, fz_v, ft_v;
  logic [lchf_pkg::Q_W-1:0] fx_q, fy_q, fz_q, ft_q;
  lchf_pkg::ray_t           fin_dl_q [0:lchf_pkg::SCALE_LAT-1];

  lchf_scale u_scale_x (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (i_v_q),
    .mag_i (mag21(i_ray_q.mx)), .num_i (i_num_q), .den_i (i_den_q),
    .valid_o (fx_v), .q_o (fx_q)
  );

  lchf_scale u_scale_y (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (i_v_q),
    .mag_i (mag21(i_ray_q.my)), .num_i (i_num_q), .den_i (i_den_q),
    .valid_o (fy_v), .q_o (fy_q)
  );

  lchf_scale u_scale_z (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (i_v_q),
    .mag_i (mag21(i_ray_q.mz)), .num_i (i_num_q), .den_i (i_den_q),
    .valid_o (fz_v), .q_o (fz_q)
  );

  lchf_scale u_scale_t (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (i_v_q),
    .mag_i ({1'b0, i_ray_q.en}), .num_i (i_num_q), .den_i (i_den_q),
    .valid_o (ft_v), .q_o (ft_q)
  );

  always_ff @(posedge clk_i) begin
    fin_dl_q[0] <= i_ray_q;
    for (int k = 1; k < lchf_pkg::SCALE_LAT; k++) begin
      fin_dl_q[k] <= fin_dl_q[k-1];
    end
  end

  lchf_pkg::ray_t     fin;
  logic signed [42:0] hx_w, hy_w, hz_w;
  logic signed [41:0] ht_w;
  logic               done_q;
  logic [23:0]        hit_x_q, hit_y_q, hit_z_q;
  logic [31:0]        hit_time_q;

  assign fin  = fin_dl_q[lchf_pkg::SCALE_LAT-1];
  assign hx_w = $signed({{19{fin.sx[23]}}, fin.sx}) + apply(fin.mx, fx_q);
  assign hy_w = $signed({{19{fin.sy[23]}}, fin.sy}) + apply(fin.my, fy_q);
  assign hz_w = $signed({{19{fin.sz[23]}}, fin.sz}) + apply(fin.mz, fz_q);
  assign ht_w = $signed({{10{fin.st[31]}}, fin.st}) + $signed({1'b0, ft_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= fx_v && fy_v && fz_v && ft_v;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_x_q    <= clamp24(hx_w);
    hit_y_q    <= clamp24(hy_w);
    hit_z_q    <= clamp24(hz_w);
    hit_time_q <= clamp32(ht_w);
  end

  assign done_o     = done_q;
  assign hit_x_o    = hit_x_q;
  assign hit_y_o    = hit_y_q;
  assign hit_z_o    = hit_z_q;
  assign hit_time_o = hit_time_q;

endmodule

// ===== bench/line_cylinder_hit_finder_test.sv =====
module line_cylinder_hit_finder_test;

  localparam int unsigned SETTLE_CYCLES = 170;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam longint unsigned STEP_SAT = 64'd1 << 40;

  typedef enum logic [1:0] {
    OP_ITEM,
    OP_CFG,
    OP_DRAIN
  } op_kind_e;

  typedef struct {
    logic signed [23:0] sx;
    logic signed [23:0] sy;
    logic signed [23:0] sz;
    logic signed [31:0] st;
    logic signed [20:0] mx;
    logic signed [20:0] my;
    logic signed [20:0] mz;
    logic [19:0]        en;
    logic signed [1:0]  chg;
  } particle_t;

  typedef struct {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
    logic signed [31:0] t;
  } hit_t;

  typedef struct {
    op_kind_e           kind;
    particle_t          p;
    lchf_pkg::cfg_reg_e idx;
    logic [22:0]        data;
    int                 gap;
  } op_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  lchf_pkg::cfg_reg_e cfg_index_i;
  logic [22:0]        cfg_data_i;
  logic signed [23:0] start_x_i;
  logic signed [23:0] start_y_i;
  logic signed [23:0] start_z_i;
  logic signed [31:0] start_time_i;
  logic signed [20:0] mom_x_i;
  logic signed [20:0] mom_y_i;
  logic signed [20:0] mom_z_i;
  logic [19:0]        energy_i;
  logic signed [1:0]  charge_i;
  logic               done_o;
  logic signed [23:0] hit_x_o;
  logic signed [23:0] hit_y_o;
  logic signed [23:0] hit_z_o;
  logic signed [31:0] hit_time_o;

  line_cylinder_hit_finder i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .start_x_i    (start_x_i),
    .start_y_i    (start_y_i),
    .start_z_i    (start_z_i),
    .start_time_i (start_time_i),
    .mom_x_i      (mom_x_i),
    .mom_y_i      (mom_y_i),
    .mom_z_i      (mom_z_i),
    .energy_i     (energy_i),
    .charge_i     (charge_i),
    .done_o       (done_o),
    .hit_x_o      (hit_x_o),
    .hit_y_o      (hit_y_o),
    .hit_z_o      (hit_z_o),
    .hit_time_o   (hit_time_o)
  );

  op_t     pending_ops[$];
  hit_t    expected_hits[$];
  longint  radius_q = 100000;
  longint  half_q = 1000000;
  longint  ptmin_q = 1000;
  bit      field_q = 1'b0;
  longint  radius_shadow = 100000;
  longint  half_shadow = 1000000;
  int      mismatches = 0;
  int      items_sent = 0;
  int      hits_seen = 0;
  int      cfg_writes = 0;
  int      gap_cnt;
  int      settle_cnt;
  int      idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic longint unsigned floor_sqrt(input logic [127:0] v);
    logic [127:0] r;
    logic [127:0] c;
    r = '0;
    for (int b = 45; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= v) r = c;
    end
    return r[63:0];
  endfunction

  // round(c * num / den), halves away from zero, magnitude capped at 2^40
  function automatic longint scale_step(input longint c, input longint num, input longint den);
    logic [127:0] n;
    logic [127:0] q;
    longint       mag;
    if (den == 0) return 0;
    mag = (c < 0) ? -c : c;
    n = 128'(mag) * 128'(num) * 2 + 128'(den);
    q = n / (128'(den) * 2);
    if (q > 128'(STEP_SAT)) q = 128'(STEP_SAT);
    return (c < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic bit predict_hit(input particle_t p, output hit_t h);
    longint       sx, sy, sz, mx, my, mz, rsq, r0sq, ptsq, dot, dmag, root, num, den, zt;
    logic [127:0] disc;
    sx = p.sx; sy = p.sy; sz = p.sz;
    mx = p.mx; my = p.my; mz = p.mz;
    h = '{default: '0};
    rsq = radius_q * radius_q;
    r0sq = sx * sx + sy * sy;
    if (r0sq > rsq || sz > half_q || sz < -half_q) return 0;
    ptsq = mx * mx + my * my;
    if (ptsq == 0 || ptsq < ptmin_q * ptmin_q) return 0;
    if (p.chg != 0 && field_q) return 0;
    dot = mx * sx + my * sy;
    dmag = (dot < 0) ? -dot : dot;
    disc = 128'(ptsq) * 128'(rsq - r0sq) + 128'(dmag) * 128'(dmag);
    root = floor_sqrt(disc);
    if (root < dot) return 0;
    num = root - dot;
    den = ptsq;
    zt = sz + scale_step(mz, num, den);
    if ((zt > half_q || zt < -half_q) && mz != 0) begin
      num = (mz > 0) ? half_q - sz : half_q + sz;
      den = (mz > 0) ? mz : -mz;
    end
    h.x = 24'(clip(sx + scale_step(mx, num, den), -8388608, 8388607));
    h.y = 24'(clip(sy + scale_step(my, num, den), -8388608, 8388607));
    h.z = 24'(clip(sz + scale_step(mz, num, den), -8388608, 8388607));
    h.t = 32'(clip(longint'(p.st) + scale_step(longint'(p.en), num, den),
                   -64'sd2147483648, 64'sd2147483647));
    return 1;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    logic nxt_start;
    logic nxt_cfg;
    op_t  op;
    if (!rst_ni) begin
      start_i      <= 1'b0;
      cfg_valid_i  <= 1'b0;
      cfg_index_i  <= lchf_pkg::CFG_LAYER_RADIUS;
      cfg_data_i   <= '0;
      start_x_i    <= '0;
      start_y_i    <= '0;
      start_z_i    <= '0;
      start_time_i <= '0;
      mom_x_i      <= '0;
      mom_y_i      <= '0;
      mom_z_i      <= '0;
      energy_i     <= '0;
      charge_i     <= '0;
      gap_cnt      <= 0;
      settle_cnt   <= 0;
    end else begin
      nxt_start = start_i && busy_o;
      nxt_cfg = cfg_valid_i && !cfg_ready_o;
      if (!nxt_start && !nxt_cfg) begin
        if (gap_cnt > 0) begin
          gap_cnt <= gap_cnt - 1;
        end else if (pending_ops.size() > 0) begin
          op = pending_ops[0];
          case (op.kind)
            OP_ITEM: begin
              void'(pending_ops.pop_front());
              start_x_i    <= op.p.sx;
              start_y_i    <= op.p.sy;
              start_z_i    <= op.p.sz;
              start_time_i <= op.p.st;
              mom_x_i      <= op.p.mx;
              mom_y_i      <= op.p.my;
              mom_z_i      <= op.p.mz;
              energy_i     <= op.p.en;
              charge_i     <= op.p.chg;
              nxt_start = 1'b1;
              gap_cnt <= op.gap;
            end
            OP_CFG: begin
              void'(pending_ops.pop_front());
              cfg_index_i <= op.idx;
              cfg_data_i  <= op.data;
              nxt_cfg = 1'b1;
            end
            default: begin
              if (!start_i && expected_hits.size() == 0) begin
                if (settle_cnt >= SETTLE_CYCLES) begin
                  void'(pending_ops.pop_front());
                  settle_cnt <= 0;
                end else begin
                  settle_cnt <= settle_cnt + 1;
                end
              end
            end
          endcase
        end
      end
      start_i <= nxt_start;
      cfg_valid_i <= nxt_cfg;
    end
  end

  // monitor and checker
  always @(posedge clk_i) begin
    hit_t h;
    hit_t e;
    if (rst_ni) begin
      if (done_o) begin
        hits_seen++;
        if (expected_hits.size() == 0) begin
          $error("unexpected hit x=%0d y=%0d z=%0d t=%0d",
                 hit_x_o, hit_y_o, hit_z_o, hit_time_o);
          mismatches++;
        end else begin
          e = expected_hits.pop_front();
          if (hit_x_o !== e.x) begin
            $error("hit_x expected %0d actual %0d", e.x, hit_x_o);
            mismatches++;
          end
          if (hit_y_o !== e.y) begin
            $error("hit_y expected %0d actual %0d", e.y, hit_y_o);
            mismatches++;
          end
          if (hit_z_o !== e.z) begin
            $error("hit_z expected %0d actual %0d", e.z, hit_z_o);
            mismatches++;
          end
          if (hit_time_o !== e.t) begin
            $error("hit_time expected %0d actual %0d", e.t, hit_time_o);
            mismatches++;
          end
        end
      end
      if (start_i && !busy_o) begin
        items_sent++;
        if (predict_hit('{start_x_i, start_y_i, start_z_i, start_time_i, mom_x_i, mom_y_i,
                          mom_z_i, energy_i, charge_i}, h))
          expected_hits = {expected_hits, h};
      end
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_writes++;
        case (cfg_index_i)
          lchf_pkg::CFG_LAYER_RADIUS: radius_q = cfg_data_i;
          lchf_pkg::CFG_HALF_LENGTH:  half_q = cfg_data_i;
          lchf_pkg::CFG_PT_MIN:       ptmin_q = cfg_data_i[19:0];
          default:                    field_q = cfg_data_i[0];
        endcase
      end
      if (done_o || (start_i && !busy_o) || (cfg_valid_i && cfg_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout after %0d idle cycles", idle_cycles);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  function automatic int pick_gap(input bit burst);
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  function automatic longint rand_span(input longint lo, input longint hi);
    return lo + longint'({$urandom, $urandom} % longint'(hi - lo + 1));
  endfunction

  task automatic add_item(input particle_t p, input int gap);
    op_t op;
    op = '{kind: OP_ITEM, p: p, idx: lchf_pkg::CFG_LAYER_RADIUS, data: '0, gap: gap};
    pending_ops = {pending_ops, op};
  endtask

  task automatic add_cfg(input lchf_pkg::cfg_reg_e idx, input logic [22:0] data);
    op_t op;
    op = '{kind: OP_CFG, p: '{default: '0}, idx: idx, data: data, gap: 0};
    pending_ops = {pending_ops, op};
  endtask

  task automatic add_drain();
    op_t op;
    op = '{kind: OP_DRAIN, p: '{default: '0}, idx: lchf_pkg::CFG_LAYER_RADIUS, data: '0,
           gap: 0};
    pending_ops = {pending_ops, op};
  endtask

  task automatic set_barrel(input longint r, input longint hl, input longint pt, input bit fld);
    add_drain();
    add_cfg(lchf_pkg::CFG_LAYER_RADIUS, r[22:0]);
    add_cfg(lchf_pkg::CFG_HALF_LENGTH, hl[22:0]);
    add_cfg(lchf_pkg::CFG_PT_MIN, pt[22:0]);
    add_cfg(lchf_pkg::CFG_FIELD_ON, {22'd0, fld});
    radius_shadow = r;
    half_shadow = hl;
  endtask

  // mostly tracks starting inside the barrel, the rest raw noise
  task automatic add_random_items(input int count);
    particle_t p;
    longint    lim;
    int        mode;
    for (int i = 0; i < count; i++) begin
      mode = $urandom_range(0, 99);
      p.st  = $urandom;
      p.en  = 20'($urandom);
      p.chg = 2'($urandom);
      if (mode < 78) begin
        lim = radius_shadow / 2;
        p.sx = 24'(rand_span(-lim, lim));
        p.sy = 24'(rand_span(-lim, lim));
        p.sz = 24'(rand_span(-half_shadow, half_shadow));
        if ($urandom_range(0, 1)) begin
          p.mx = 21'($urandom);
          p.my = 21'($urandom);
          p.mz = 21'($urandom);
        end else begin
          p.mx = 21'(rand_span(-3000, 3000));
          p.my = 21'(rand_span(-3000, 3000));
          p.mz = 21'(rand_span(-6000, 6000));
        end
        if ($urandom_range(0, 9) == 0) p.en = 20'(rand_span(0, 3));
      end else begin
        p.sx = 24'($urandom);
        p.sy = 24'($urandom);
        p.sz = 24'($urandom);
        p.mx = 21'($urandom);
        p.my = 21'($urandom);
        p.mz = 21'($urandom);
      end
      add_item(p, pick_gap(((i / 40) % 4) == 3));
    end
  endtask

  task automatic add_directed_items();
    // zero transverse momentum
    add_item('{0, 0, 0, 100, 0, 0, 5000, 1000, 0}, 0);
    // below threshold
    add_item('{0, 0, 0, 100, 500, 500, 0, 1000, 0}, 0);
    // plain barrel crossing
    add_item('{1000, -2000, 0, 0, 3000, 4000, 100, 200, 0}, 0);
    // charged, field off
    add_item('{0, 0, 0, -5, -3000, 0, 0, 77, 1}, 1);
    add_item('{0, 0, 0, -5, 0, -3000, 0, 77, -2}, 0);
    // start outside radially and beyond half length
    add_item('{200000, 0, 0, 0, 3000, 0, 0, 10, 0}, 0);
    add_item('{0, 0, 1000001, 0, 3000, 0, 0, 10, 0}, 0);
    add_item('{0, 0, -1000001, 0, 3000, 0, 0, 10, 0}, 2);
    // end cap clipping toward +z and -z
    add_item('{0, 0, 10, 0, 1000, 0, 1048575, 1048575, 0}, 0);
    add_item('{0, 0, -10, 0, 0, 1000, -1048576, 1048575, 0}, 0);
    // zero energy and time extremes
    add_item('{5, 5, 0, 32'h7fffffff, 2000, 2000, 0, 0, 0}, 0);
    add_item('{5, 5, 0, 32'sh80000000, -2000, -2000, 0, 1048575, 0}, 0);
    add_item('{0, 0, 0, 32'h7fffff00, 1000, 0, 0, 1048575, 0}, 3);
    add_item('{-100000, 0, 1000000, 0, -1000, 0, 0, 1, 0}, 0);
    add_item('{0, 100000, -1000000, 0, 0, 1048575, -1048576, 5, -1}, 0);
    add_item('{-8388608, -8388608, -8388608, 0, -1048576, -1048576, 0, 0, 0}, 0);
    add_item('{8388607, 8388607, 8388607, 0, 1048575, 1048575, 1048575, 0, 0}, 0);
  endtask

  initial begin
    particle_t p;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    add_directed_items();
    add_random_items(160);

    // field on: charged tracks are dropped, pt minimum off, zero radius and half length
    set_barrel(0, 0, 0, 1'b1);
    add_item('{0, 0, 0, 0, 1, 0, 0, 9, 0}, 0);
    add_item('{0, 0, 0, 0, -1, 0, 5, 9, 1}, 0);
    add_item('{0, 0, 0, 0, 0, 1, 5, 9, 0}, 0);
    add_random_items(60);

    set_barrel(8388607, 8388607, 0, 1'b1);
    add_item('{0, 0, 0, 0, 3, 4, 1, 9, 1}, 0);
    add_item('{0, 0, 0, 0, 3, 4, 1, 9, -2}, 0);
    add_random_items(200);

    set_barrel(8388607, 8388607, 1048575, 1'b0);
    add_item('{0, 0, 0, 0, -1048576, -1048576, 7, 9, 0}, 0);
    add_item('{0, 0, 0, 0, 1048575, 1048575, -7, 9, 0}, 0);
    add_item('{0, 0, 0, 0, 1048575, 0, 0, 9, 0}, 0);
    add_random_items(120);

    set_barrel(1, 1, 1, 1'b0);
    add_random_items(100);

    for (int ph = 0; ph < 4; ph++) begin
      set_barrel($urandom_range(0, 8388607), $urandom_range(0, 8388607),
                 $urandom_range(0, 4000), 1'($urandom_range(0, 1)));
      add_random_items(120);
    end

    set_barrel(100000, 1000000, 1000, 1'b0);
    add_random_items(30);
    add_drain();

    wait (pending_ops.size() == 0);
    repeat (SETTLE_CYCLES + 20) @(posedge clk_i);
    if (expected_hits.size() != 0) begin
      $error("%0d expected hits never arrived", expected_hits.size());
      mismatches++;
    end
    $display("sent %0d particles over %0d register writes, %0d hits checked",
             items_sent, cfg_writes, hits_seen);
    $display("covered barrel, end cap, threshold, field and outside-start cases");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/lchf_pkg.sv
hw/rtl/lchf_sqrt.sv
hw/rtl/lchf_scale.sv
hw/rtl/line_cylinder_hit_finder.sv
bench/line_cylinder_hit_finder_test.sv
